FILE: rtl/rwod_pkg.sv
`timescale 1ns / 1ps

package rwod_pkg;

    // window geometry
    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // field widths
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned K_W          = 8;
    localparam int unsigned KK_W         = 2 * K_W;
    localparam int unsigned S_TDATA_W    = 16;
    localparam int unsigned M_TDATA_W    = 8;

    // K reset value is 3.0 in Q4.4; K squared is kept instead of K
    localparam int unsigned K_RESET      = 48;
    localparam int unsigned KK_RESET     = K_RESET * K_RESET;

    // running statistics
    localparam int unsigned SUM_W        = SAMPLE_W + PTR_W;
    localparam int unsigned SQ_W         = 2 * SAMPLE_W + PTR_W;
    localparam int unsigned V_W          = 2 * SUM_W;
    localparam int unsigned VL_W         = (V_W + 1) / 2;
    localparam int unsigned VH_W         = V_W - VL_W;
    localparam int unsigned DP2_W        = 2 * SAMPLE_W;
    localparam int unsigned SQR_W        = 2 * SAMPLE_W;

    // comparison operands
    localparam int unsigned C_A          = 256 * (WINDOW_DEPTH - 1);
    localparam int unsigned C_J          = 256 * WINDOW_DEPTH * (WINDOW_DEPTH - 1);
    localparam int unsigned LHS_A_W      = V_W + 8 + PTR_W;
    localparam int unsigned LHS_J_W      = DP2_W + 8 + 2 * PTR_W;
    localparam int unsigned KV_W         = V_W + KK_W;
    localparam int unsigned RHS_A_W      = KV_W + PTR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_VAR,
        S_K0,
        S_K1,
        S_RHS,
        S_DONE
    } t_state;

    // step strobes from sequencer to datapath
    typedef struct packed {
        logic ld;
        logic sq;
        logic vr;
        logic k0;
        logic k1;
        logic rhs;
        logic commit;
    } t_ctl;

endpackage

FILE: rtl/rwod_ram.sv
`timescale 1ns / 1ps

module rwod_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rwod_ctrl.sv
`timescale 1ns / 1ps

module rwod_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_out_free,
    output logic          o_s_ready,
    output rwod_pkg::t_ctl o_ctl
);

    rwod_pkg::t_state r_state;
    rwod_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwod_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwod_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = rwod_pkg::S_SQ;
                end
            end
            rwod_pkg::S_SQ:  n_state = rwod_pkg::S_VAR;
            rwod_pkg::S_VAR: n_state = rwod_pkg::S_K0;
            rwod_pkg::S_K0:  n_state = rwod_pkg::S_K1;
            rwod_pkg::S_K1:  n_state = rwod_pkg::S_RHS;
            rwod_pkg::S_RHS: n_state = rwod_pkg::S_DONE;
            rwod_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = rwod_pkg::S_IDLE;
                end
            end
            default: n_state = rwod_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready    = 1'b0;
        o_ctl        = '0;
        unique case (r_state)
            rwod_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                o_ctl.ld  = i_s_valid;
            end
            rwod_pkg::S_SQ:   o_ctl.sq  = 1'b1;
            rwod_pkg::S_VAR:  o_ctl.vr  = 1'b1;
            rwod_pkg::S_K0:   o_ctl.k0  = 1'b1;
            rwod_pkg::S_K1:   o_ctl.k1  = 1'b1;
            rwod_pkg::S_RHS:  o_ctl.rhs = 1'b1;
            rwod_pkg::S_DONE: o_ctl.commit = i_out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/rwod_dp.sv
`timescale 1ns / 1ps

module rwod_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rwod_pkg::t_ctl                    i_ctl,
    input  logic [rwod_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                              i_cfg_we,
    input  logic [rwod_pkg::K_W-1:0]          i_cfg_data,
    input  logic [rwod_pkg::SAMPLE_W-1:0]     i_ram_rdata,
    output logic [rwod_pkg::PTR_W-1:0]        o_ram_addr,
    output logic [rwod_pkg::SAMPLE_W-1:0]     o_ram_wdata,
    output logic                              o_out_free,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic                              o_anomaly,
    output logic                              o_big_jump,
    output logic                              o_window_full
);

    localparam int unsigned N = rwod_pkg::WINDOW_DEPTH;

    // statistics state
    logic [rwod_pkg::KK_W-1:0]     r_kk;
    logic [rwod_pkg::PTR_W-1:0]    r_wptr, n_wptr;
    logic [rwod_pkg::CNT_W-1:0]    r_fill, n_fill;
    logic [rwod_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [rwod_pkg::SQ_W-1:0]     r_sq, n_sq;
    logic [rwod_pkg::SAMPLE_W-1:0] r_prev;

    // per-beat working registers
    logic [rwod_pkg::SAMPLE_W-1:0] r_x;
    logic [rwod_pkg::V_W-1:0]      r_ss, r_v, r_dm2;
    logic [rwod_pkg::SUM_W-1:0]    r_dm;
    logic [rwod_pkg::SAMPLE_W-1:0] r_dp;
    logic [rwod_pkg::DP2_W-1:0]    r_dp2;
    logic [rwod_pkg::SQR_W-1:0]    r_oldsq, r_xsq;
    logic [rwod_pkg::LHS_A_W-1:0]  r_lhs_a;
    logic [rwod_pkg::LHS_J_W-1:0]  r_lhs_j;
    logic [rwod_pkg::KV_W-1:0]     r_kv_lo, r_kv;
    logic [rwod_pkg::RHS_A_W-1:0]  r_rhs_a;

    // result register
    logic r_ovalid, r_anom, r_jump, r_ofull;
    logic n_anom, n_jump;

    logic                          w_full;
    logic [rwod_pkg::SAMPLE_W-1:0] w_old;
    logic [rwod_pkg::SUM_W-1:0]    w_nx;
    logic [rwod_pkg::V_W-1:0]      w_nq;

    assign w_full = (r_fill == rwod_pkg::CNT_W'(N));
    // slot contents only count once the window is full
    assign w_old  = w_full ? i_ram_rdata : '0;
    assign w_nx   = rwod_pkg::SUM_W'(r_x) * rwod_pkg::SUM_W'(N);
    assign w_nq   = rwod_pkg::V_W'(r_sq) * rwod_pkg::V_W'(N);

    always_comb begin
        n_wptr = (r_wptr == rwod_pkg::PTR_W'(N - 1)) ? '0 : r_wptr + 1'b1;
        n_fill = w_full ? r_fill : r_fill + 1'b1;
        n_sum  = r_sum - rwod_pkg::SUM_W'(w_old) + rwod_pkg::SUM_W'(r_x);
        n_sq   = r_sq - rwod_pkg::SQ_W'(r_oldsq) + rwod_pkg::SQ_W'(r_xsq);
        if (w_full) begin
            n_anom = rwod_pkg::RHS_A_W'(r_lhs_a) > r_rhs_a;
            n_jump = rwod_pkg::KV_W'(r_lhs_j) > r_kv;
        end else begin
            n_anom = 1'b0;
            n_jump = (r_fill != '0) && (r_x != r_prev);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kk     <= rwod_pkg::KK_W'(rwod_pkg::KK_RESET);
            r_wptr   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kk <= rwod_pkg::KK_W'(i_cfg_data) * rwod_pkg::KK_W'(i_cfg_data);
            end
            if (i_ctl.commit) begin
                r_wptr   <= n_wptr;
                r_fill   <= n_fill;
                r_sum    <= n_sum;
                r_sq     <= n_sq;
                r_prev   <= r_x;
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_x <= i_sample;
        end
        if (i_ctl.sq) begin
            r_ss <= rwod_pkg::V_W'(r_sum) * rwod_pkg::V_W'(r_sum);
            r_dm <= (w_nx >= r_sum) ? w_nx - r_sum : r_sum - w_nx;
            r_dp <= (r_x >= r_prev) ? r_x - r_prev : r_prev - r_x;
        end
        if (i_ctl.vr) begin
            r_v     <= (w_nq >= r_ss) ? w_nq - r_ss : '0;
            r_dm2   <= rwod_pkg::V_W'(r_dm) * rwod_pkg::V_W'(r_dm);
            r_dp2   <= rwod_pkg::DP2_W'(r_dp) * rwod_pkg::DP2_W'(r_dp);
            r_oldsq <= rwod_pkg::SQR_W'(w_old) * rwod_pkg::SQR_W'(w_old);
            r_xsq   <= rwod_pkg::SQR_W'(r_x) * rwod_pkg::SQR_W'(r_x);
        end
        if (i_ctl.k0) begin
            r_kv_lo <= rwod_pkg::KV_W'(r_v[rwod_pkg::VL_W-1:0]) * rwod_pkg::KV_W'(r_kk);
            r_lhs_a <= rwod_pkg::LHS_A_W'(r_dm2) * rwod_pkg::LHS_A_W'(rwod_pkg::C_A);
            r_lhs_j <= rwod_pkg::LHS_J_W'(r_dp2) * rwod_pkg::LHS_J_W'(rwod_pkg::C_J);
        end
        if (i_ctl.k1) begin
            r_kv <= r_kv_lo
                  + ((rwod_pkg::KV_W'(r_v[rwod_pkg::V_W-1:rwod_pkg::VL_W])
                      * rwod_pkg::KV_W'(r_kk)) << rwod_pkg::VL_W);
        end
        if (i_ctl.rhs) begin
            r_rhs_a <= rwod_pkg::RHS_A_W'(r_kv) * rwod_pkg::RHS_A_W'(N);
        end
        if (i_ctl.commit) begin
            r_anom  <= n_anom;
            r_jump  <= n_jump;
            r_ofull <= (n_fill == rwod_pkg::CNT_W'(N));
        end
    end

    assign o_ram_addr    = r_wptr;
    assign o_ram_wdata   = r_x;
    assign o_out_free    = !r_ovalid || i_m_tready;
    assign o_m_tvalid    = r_ovalid;
    assign o_anomaly     = r_anom;
    assign o_big_jump    = r_jump;
    assign o_window_full = r_ofull;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rwod_pkg::CNT_W'(N))
        else $error("fill count above window depth");

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |=> (r_wptr == (($past(r_wptr) == rwod_pkg::PTR_W'(N - 1))
                                     ? '0 : $past(r_wptr) + 1'b1)))
        else $error("write pointer did not advance by one slot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> (!r_ovalid || i_m_tready))
        else $error("result overwritten before it was taken");

    a_anom_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_anom) |-> r_ofull)
        else $error("anomaly flagged on a partial window");
`endif

endmodule

FILE: rtl/rolling_window_outlier_detector.sv
`timescale 1ns / 1ps
// Channel   | Direction | Beat fields (tdata, low bit first)
// s_axis    | in        | sample[15:0]
// m_axis    | out       | anomaly[0], big_jump[1], window_full[2], zero pad [7:3]
// cfg       | in        | sigma_multiplier_q4[7:0] (K in Q4.4), always ready
//
// One input beat passes through the accept step and then six sequencer steps
// (squares, variance, two halves of V*K^2, scaling, compare and write-back);
// the steps split the wide multiplies. Reset (synchronous, active low) clears
// pointer, fill count, sums, previous sample and result valid; K returns to 3.0.
// The window memory is not cleared: a slot's old contents count only once the window is full.
// A stalled m_axis holds the last step; s_axis is ready only between beats.
module rolling_window_outlier_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rwod_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,   // sample
    // master side
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [rwod_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,   // anomaly, big_jump, window_full
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rwod_pkg::K_W-1:0]           i_cfg_data
);

    rwod_pkg::t_ctl                w_ctl;
    logic                          w_out_free;
    logic [rwod_pkg::PTR_W-1:0]    w_ram_addr;
    logic [rwod_pkg::SAMPLE_W-1:0] w_ram_wdata;
    logic [rwod_pkg::SAMPLE_W-1:0] w_ram_rdata;
    logic                          w_anomaly, w_big_jump, w_window_full;

    // K is taken at any time; the source keeps writes to the gaps between beats
    assign o_cfg_ready = 1'b1;

    rwod_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_s_ready  (o_s_axis_tready),
        .o_ctl      (w_ctl)
    );

    // sample window: read the slot about to be replaced on accept,
    // overwrite it with the new sample at commit
    rwod_ram #(
        .WIDTH (rwod_pkg::SAMPLE_W),
        .DEPTH (rwod_pkg::WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ctl.commit),
        .i_waddr (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ctl.ld),
        .i_raddr (w_ram_addr),
        .o_rdata (w_ram_rdata)
    );

    rwod_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_sample      (i_s_axis_tdata[rwod_pkg::SAMPLE_W-1:0]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_ram_rdata   (w_ram_rdata),
        .o_ram_addr    (w_ram_addr),
        .o_ram_wdata   (w_ram_wdata),
        .o_out_free    (w_out_free),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_anomaly     (w_anomaly),
        .o_big_jump    (w_big_jump),
        .o_window_full (w_window_full)
    );

    assign o_m_axis_tdata = {{(rwod_pkg::M_TDATA_W - 3){1'b0}},
                             w_window_full, w_big_jump, w_anomaly};

endmodule
